/* design/htnh_pkg.sv */
package htnh_pkg;

  localparam int RANK_W     = 10;
  localparam int COUNT_W    = 11;
  localparam int HOP_W      = 5;
  localparam int DEPTH_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_NODES  = 1024;

  localparam logic [COUNT_W-1:0] MAX_NODES_C = COUNT_W'(MAX_NODES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_RANK   = 1'b0,
    REG_NODE_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [RANK_W-1:0]  own_rank;
    logic [COUNT_W-1:0] node_count;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [RANK_W-1:0] next_rank;
    logic [HOP_W-1:0]  hop_count;
  } route_t;

  // position of the highest set bit; 0 for a zero word
  function automatic logic [DEPTH_W-1:0] msb_pos(input logic [COUNT_W-1:0] v);
    logic [DEPTH_W-1:0] p;
    p = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (v[i]) p = DEPTH_W'(i);
    end
    return p;
  endfunction

endpackage

/* design/htnh_cfg.sv */
module htnh_cfg
  import htnh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  output cfg_t                 cfg
);

  logic [RANK_W-1:0]  own_rank_r,   own_rank_nxt;
  logic [COUNT_W-1:0] node_count_r, node_count_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    own_rank_nxt   = own_rank_r;
    node_count_nxt = node_count_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OWN_RANK:   own_rank_nxt   = cfg_wdata[RANK_W-1:0];
        REG_NODE_COUNT: node_count_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rank_r   <= '0;
      node_count_r <= MAX_NODES_C;
    end else begin
      own_rank_r   <= own_rank_nxt;
      node_count_r <= node_count_nxt;
    end
  end

  assign cfg.own_rank   = own_rank_r;
  assign cfg.node_count = node_count_r;

endmodule

/* design/htnh_lookup.sv */
module htnh_lookup
  import htnh_pkg::*;
(
  input  cfg_t              cfg,
  input  logic [RANK_W-1:0] dest_rank,
  output route_t            route
);

  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] a, b, x, y, diff;
  logic [DEPTH_W-1:0] da, db, sh, dm, bl, dl, sub_sh;
  logic               own_deeper, is_self, dest_ok, own_ok, in_sub;
  logic [RANK_W-1:0]  parent_of_own;
  logic [COUNT_W-1:0] hop_sum;
  logic [COUNT_W-1:0] nxt_wide;

  assign limit = (cfg.node_count > MAX_NODES_C) ? MAX_NODES_C : cfg.node_count;

  assign a  = {1'b0, cfg.own_rank} + COUNT_W'(1);
  assign b  = {1'b0, dest_rank} + COUNT_W'(1);
  assign da = msb_pos(a);
  assign db = msb_pos(b);

  // bring both to the shallower depth, then strip the differing tail
  assign own_deeper = da > db;
  assign sh   = own_deeper ? (da - db) : (db - da);
  assign dm   = own_deeper ? db : da;
  assign x    = own_deeper ? (a >> sh) : a;
  assign y    = own_deeper ? b : (b >> sh);
  assign diff = x ^ y;
  assign bl   = (diff == '0) ? '0 : (msb_pos(diff) + DEPTH_W'(1));
  assign dl   = dm - bl;

  assign hop_sum = COUNT_W'(da) + COUNT_W'(db) - (COUNT_W'(dl) << 1);

  assign in_sub   = (dl == da);
  assign sub_sh   = db - da - DEPTH_W'(1);
  assign nxt_wide = in_sub ? ((b >> sub_sh) - COUNT_W'(1))
                           : ((a >> 1) - COUNT_W'(1));

  assign parent_of_own = (cfg.own_rank - RANK_W'(1)) >> 1;
  assign is_self = dest_rank == cfg.own_rank;
  assign dest_ok = {1'b0, dest_rank} < limit;
  assign own_ok  = ({1'b0, cfg.own_rank} < limit)
                || ((cfg.own_rank != '0) && ({1'b0, parent_of_own} < limit));

  always_comb begin
    route = '0;
    if (is_self) begin
      route.found     = 1'b1;
      route.next_rank = cfg.own_rank;
    end else if (dest_ok && own_ok) begin
      route.found     = 1'b1;
      route.next_rank = nxt_wide[RANK_W-1:0];
      route.hop_count = hop_sum[HOP_W-1:0];
    end
  end

endmodule

/* design/heap_tree_next_hop_router.sv */
// Next-hop lookup in a heap-indexed binary tree (children 2r+1, 2r+2).
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_wdata;
// index 0 sets own_rank (low 10 bits), index 1 sets node_count. cfg_ready
// is always high; write only while no lookup is in flight.
// Request channel: a transaction is taken at each edge with start high and
// busy low. busy never rises, so one lookup is taken every cycle.
// Result channel: out_valid strobes for one cycle with out_found,
// out_next_rank and out_hop_count. A lookup passes from the accepting edge
// through one input register, the lookup logic and one result register.
// Throughput is one lookup per cycle, set by the single-pass lookup logic.
// Reset (rst_n low, synchronous) drops any lookup in flight and restores
// own_rank = 0 and node_count = 1024.
// The receiver has no way to stall; each result is shown exactly once.
module heap_tree_next_hop_router
  import htnh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [RANK_W-1:0]    in_dest_rank,
  output logic                 out_valid,
  output logic                 out_found,
  output logic [RANK_W-1:0]    out_next_rank,
  output logic [HOP_W-1:0]     out_hop_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_wdata
);

  cfg_t   cfg;
  route_t route;

  logic              in_vld_r;
  logic [RANK_W-1:0] dest_r;
  logic              out_vld_r;
  route_t            res_r;

  assign busy = 1'b0;

  htnh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  htnh_lookup u_lookup (
    .cfg       (cfg),
    .dest_rank (dest_r),
    .route     (route)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dest_r <= in_dest_rank;
    res_r  <= route;
  end

  assign out_valid     = out_vld_r;
  assign out_found     = res_r.found;
  assign out_next_rank = res_r.next_rank;
  assign out_hop_count = res_r.hop_count;

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> in_vld_r)
    else $error("accepted transaction not captured");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid)
    else $error("result strobe missing");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r))
    else $error("result without request");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_next_rank == '0 && out_hop_count == '0)
    else $error("failed lookup carries data");

  a_self: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found && out_hop_count == '0 |-> out_next_rank == cfg.own_rank)
    else $error("zero-hop route not to self");

endmodule

/* verif/heap_tree_next_hop_router_tb.sv */
module heap_tree_next_hop_router_tb
  import htnh_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int SETTLE_CYCLES    = 3;
  localparam int MAX_REPORTS      = 10;

  typedef enum bit {ROW_LOOKUP, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    cfg_reg_t           reg_idx;
    logic [COUNT_W-1:0] wdata;
    logic [RANK_W-1:0]  dest;
    bit                 typed;
    route_t             want;
  } stim_row_t;

  localparam route_t NO_ROUTE = '0;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [RANK_W-1:0]    in_dest_rank;
  logic                 out_valid;
  logic                 out_found;
  logic [RANK_W-1:0]    out_next_rank;
  logic [HOP_W-1:0]     out_hop_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index;
  logic [COUNT_W-1:0]   cfg_wdata;

  logic [RANK_W-1:0]    own_q;
  logic [COUNT_W-1:0]   count_q;
  route_t               pending_routes[$];
  int                   mismatches;
  int                   cycles;

  // directed lookups and register writes; typed rows carry the route, others go through route_lookup
  stim_row_t dir_plan [] = '{
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd0,    1'b1, '{1'b1, 10'd0,   5'd0}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd1,    1'b1, '{1'b1, 10'd1,   5'd1}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd2,    1'b1, '{1'b1, 10'd2,   5'd1}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd1023, 1'b1, '{1'b1, 10'd1,   5'd10}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd700,  1'b0, NO_ROUTE},
    '{ROW_WRITE,  REG_OWN_RANK,   11'h7FF,   10'd0,    1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd1023, 1'b1, '{1'b1, 10'd1023, 5'd0}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd0,    1'b1, '{1'b1, 10'd511, 5'd10}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd1022, 1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd511,  1'b1, '{1'b1, 10'd511, 5'd1}},
    '{ROW_WRITE,  REG_NODE_COUNT, 11'd0,     10'd0,    1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd1023, 1'b1, '{1'b1, 10'd1023, 5'd0}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd0,    1'b1, NO_ROUTE},
    '{ROW_WRITE,  REG_NODE_COUNT, 11'd2047,  10'd0,    1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd5,    1'b0, NO_ROUTE},
    '{ROW_WRITE,  REG_NODE_COUNT, 11'd1,     10'd0,    1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd0,    1'b1, NO_ROUTE},
    '{ROW_WRITE,  REG_OWN_RANK,   11'd2,     10'd0,    1'b0, NO_ROUTE},
    '{ROW_WRITE,  REG_NODE_COUNT, 11'd2,     10'd0,    1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd0,    1'b1, '{1'b1, 10'd0,   5'd1}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd1,    1'b1, '{1'b1, 10'd0,   5'd2}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd2,    1'b1, '{1'b1, 10'd2,   5'd0}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd3,    1'b1, NO_ROUTE},
    '{ROW_WRITE,  REG_OWN_RANK,   11'd0,     10'd0,    1'b0, NO_ROUTE},
    '{ROW_WRITE,  REG_NODE_COUNT, 11'd1,     10'd0,    1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd0,    1'b1, '{1'b1, 10'd0,   5'd0}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd1,    1'b1, NO_ROUTE},
    '{ROW_WRITE,  REG_NODE_COUNT, 11'd0,     10'd0,    1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd0,    1'b1, '{1'b1, 10'd0,   5'd0}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd512,  1'b1, NO_ROUTE},
    '{ROW_WRITE,  REG_OWN_RANK,   11'd5,     10'd0,    1'b0, NO_ROUTE},
    '{ROW_WRITE,  REG_NODE_COUNT, 11'd1024,  10'd0,    1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd11,   1'b1, '{1'b1, 10'd11,  5'd1}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd12,   1'b1, '{1'b1, 10'd12,  5'd1}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd2,    1'b1, '{1'b1, 10'd2,   5'd1}},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd23,   1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd1000, 1'b0, NO_ROUTE},
    '{ROW_LOOKUP, REG_OWN_RANK,   11'd0,     10'd6,    1'b0, NO_ROUTE}
  };

  heap_tree_next_hop_router i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_dest_rank  (in_dest_rank),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_next_rank (out_next_rank),
    .out_hop_count (out_hop_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned tree_depth(input int unsigned v);
    int unsigned d;
    d = 0;
    while (v > 1) begin
      v = v >> 1;
      d++;
    end
    return d;
  endfunction

  function automatic route_t route_lookup(input logic [RANK_W-1:0] dest);
    int unsigned lim, own, a, b, da, db, x, y, dx, dy;
    route_t r;
    r = NO_ROUTE;
    own = own_q;
    lim = (count_q < MAX_NODES) ? count_q : MAX_NODES;
    if (dest == own_q) begin
      r.found = 1'b1;
      r.next_rank = own_q;
      return r;
    end
    if (dest >= lim) return r;
    // absent own node can only go up, and only if its parent is present
    if (!(own < lim || (own != 0 && ((own - 1) >> 1) < lim))) return r;
    a = own + 1;
    b = dest + 1;
    da = tree_depth(a);
    db = tree_depth(b);
    x = a;
    y = b;
    dx = da;
    dy = db;
    while (dx > dy) begin
      x = x >> 1;
      dx--;
    end
    while (dy > dx) begin
      y = y >> 1;
      dy--;
    end
    while (x != y) begin
      x = x >> 1;
      y = y >> 1;
      dx--;
    end
    r.found = 1'b1;
    r.hop_count = HOP_W'(da + db - 2 * dx);
    if (x == a) r.next_rank = RANK_W'((b >> (db - da - 1)) - 1);
    else r.next_rank = RANK_W'((a >> 1) - 1);
    return r;
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic send_lookup(input logic [RANK_W-1:0] dest, input bit typed,
                             input route_t want, input int gap);
    start <= 1'b1;
    in_dest_rank <= dest;
    do @(posedge clk); while (busy);
    pending_routes.push_back(typed ? want : route_lookup(dest));
    if (gap > 0) begin
      start <= 1'b0;
      in_dest_rank <= RANK_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [COUNT_W-1:0] val,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_OWN_RANK) own_q = val[RANK_W-1:0];
    else count_q = val;
    if (!hold) cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    route_t got, want;
    if (rst_n && out_valid) begin
      got = {out_found, out_next_rank, out_hop_count};
      if (pending_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: found=%0d next=%0d hops=%0d",
                   got.found, got.next_rank, got.hop_count);
      end else begin
        want = pending_routes.pop_front();
        if (got.found !== want.found || got.next_rank !== want.next_rank ||
            got.hop_count !== want.hop_count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display(
              "mismatch: expected found=%0d next=%0d hops=%0d, got found=%0d next=%0d hops=%0d",
              want.found, want.next_rank, want.hop_count,
              got.found, got.next_rank, got.hop_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int sent, n, lim, own_v, pick;
    bit steady, hold;
    logic [COUNT_W-1:0] own_w, count_w;
    logic [RANK_W-1:0] dest;
    cycles = 0;
    mismatches = 0;
    own_q = '0;
    count_q = MAX_NODES_C;
    start = 1'b0;
    in_dest_rank = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_OWN_RANK;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < dir_plan.size(); i++) begin
      if (dir_plan[i].kind == ROW_WRITE) begin
        if (i == 0 || dir_plan[i-1].kind != ROW_WRITE) wait_idle();
        hold = (i + 1 < dir_plan.size()) && (dir_plan[i+1].kind == ROW_WRITE);
        write_reg(dir_plan[i].reg_idx, dir_plan[i].wdata, hold);
      end else begin
        send_lookup(dir_plan[i].dest, dir_plan[i].typed, dir_plan[i].want, pick_gap(1'b0));
      end
    end

    sent = 0;
    while (sent < NUM_RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: own_w = COUNT_W'($urandom_range(0, 1) << RANK_W);
        1: own_w = COUNT_W'(($urandom_range(0, 1) << RANK_W) | 1023);
        default: own_w = COUNT_W'($urandom_range(0, 2047));
      endcase
      own_v = own_w[RANK_W-1:0];
      case ($urandom_range(0, 10))
        0: count_w = 11'd0;
        1: count_w = 11'd1;
        2: count_w = 11'd1023;
        3: count_w = 11'd2047;
        4: count_w = COUNT_W'(own_v);
        5: count_w = COUNT_W'(own_v + 1);
        6: count_w = (own_v == 0) ? 11'd1 : COUNT_W'(((own_v - 1) >> 1) + 1);
        7: count_w = COUNT_W'($urandom_range(0, 2047));
        default: count_w = MAX_NODES_C;
      endcase
      write_reg(REG_OWN_RANK, own_w, 1'b1);
      write_reg(REG_NODE_COUNT, count_w, 1'b0);
      lim = (count_q < MAX_NODES) ? count_q : MAX_NODES;
      n = $urandom_range(15, 60);
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n && sent < NUM_RANDOM_ITEMS; k++) begin
        pick = $urandom_range(0, 11);
        case (pick)
          0: dest = own_q;
          1: dest = RANK_W'(2 * own_v + 1);
          2: dest = RANK_W'(2 * own_v + 2);
          3: dest = (own_v == 0) ? '0 : RANK_W'((own_v - 1) >> 1);
          4, 5: dest = (lim > 0) ? RANK_W'($urandom_range(0, lim - 1)) : RANK_W'($urandom);
          6: dest = '0;
          7: dest = '1;
          default: dest = RANK_W'($urandom);
        endcase
        send_lookup(dest, 1'b0, NO_ROUTE, pick_gap(steady));
        sent++;
      end
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_routes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
